// ----- design/table_linear_interpolator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the table linear interpolator
// Each macro expands to a concurrent assertion in simulation and to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TLI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tli assertion failed");
// Next-cycle implication.
`define TLI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tli assertion failed");
`else
`define TLI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TLI_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- design/tli_pkg.sv -----
// ----------------------------------------------------------------------------
// Table linear interpolator package
// Shared constants, codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int TABLE_POINTS_DEF = 256;

    localparam int COUNT_W  = 9;    // points_in_use width
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int REGION_W = 3;

    // Quotient bits: one integer bit and the fraction bits.
    localparam int DIV_STEPS = FRAC_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Slave tdata layout, lowest bit first.
    localparam int IDX_LSB   = 0;
    localparam int PPOS_LSB  = IDX_LSB + INDEX_W;
    localparam int PVAL_LSB  = PPOS_LSB + VALUE_W;
    localparam int QPOS_LSB  = PVAL_LSB + VALUE_W;
    localparam int S_TDATA_W = QPOS_LSB + VALUE_W;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [REGION_W-1:0] {
        REGION_INTERIOR = 3'd0,
        REGION_LOW      = 3'd1,
        REGION_HIGH     = 3'd2,
        REGION_EMPTY    = 3'd3,
        REGION_FLAT     = 3'd4
    } region_t;

    typedef enum logic [1:0] {
        SRC_ZERO   = 2'd0,
        SRC_PREV   = 2'd1,
        SRC_READ   = 2'd2,
        SRC_INTERP = 2'd3
    } res_src_t;

    typedef struct packed {
        logic     ram_write;
        logic     load_query;
        logic     load_prev;
        logic     load_cur;
        logic     load_diff;
        logic     div_step;
        logic     div_first;
        logic     mul;
        logic     set_result;
        res_src_t src;
        region_t  region;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic q_le_read;
        logic q_ge_read;
        logic read_lt_q;
        logic dx_pos;
        logic out_free;
    } dp_status_t;

endpackage

// ----- design/tli_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module tli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/tli_datapath.sv -----
// ----------------------------------------------------------------------------
// Table linear interpolator datapath
// Breakpoint RAM, search comparators, restoring divider for the fraction,
// multiplier, saturating adder and the output register.
// ----------------------------------------------------------------------------
module tli_datapath #(
    parameter int TABLE_POINTS = tli_pkg::TABLE_POINTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tli_pkg::dp_cmd_t                cmd,
    input  logic [$clog2(TABLE_POINTS)-1:0] rd_addr,
    input  logic [tli_pkg::S_TDATA_W-1:0]   s_tdata,
    output tli_pkg::dp_status_t             status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tli_pkg::VALUE_W-1:0]     m_tdata,   // value[31:0]
    output logic [tli_pkg::REGION_W-1:0]    m_tuser    // region[2:0]
);

    import tli_pkg::*;

    `include "table_linear_interpolator_assert.svh"

    localparam int AW     = $clog2(TABLE_POINTS);
    localparam int DIFF_W = VALUE_W + 1;
    localparam int REM_W  = VALUE_W + 2;
    localparam int QUOT_W = DIV_STEPS;
    localparam int PROD_W = QUOT_W + DIFF_W;
    localparam int SHR_W  = PROD_W - FRAC_W;
    localparam int SUM_W  = SHR_W + 1;

    logic [INDEX_W-1:0]         wr_index;
    logic                       wr_in_range;
    logic [2*VALUE_W-1:0]       rd_data;
    logic signed [VALUE_W-1:0]  rd_pos;
    logic signed [VALUE_W-1:0]  rd_val;

    logic signed [VALUE_W-1:0]  q_reg;
    logic signed [VALUE_W-1:0]  prev_pos_reg, prev_val_reg;
    logic signed [VALUE_W-1:0]  cur_pos_reg, cur_val_reg;
    logic signed [DIFF_W-1:0]   dx;
    logic [REM_W-1:0]           dx_reg;
    logic [REM_W-1:0]           rem_reg;
    logic signed [DIFF_W-1:0]   dy_reg;
    logic [QUOT_W-1:0]          quot_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W:0]     prod_full;

    logic [REM_W:0]             trial;
    logic                       trial_ge;
    logic signed [DIFF_W-1:0]   num;
    logic signed [SHR_W-1:0]    prod_shr;
    logic signed [SUM_W-1:0]    sum;
    logic signed [VALUE_W-1:0]  interp_sat;
    logic signed [VALUE_W-1:0]  res_value_next;
    logic signed [VALUE_W-1:0]  res_value_reg;
    region_t                    res_region_reg;
    logic                       m_tvalid_reg;
    logic [VALUE_W-1:0]         m_tdata_reg;
    logic [REGION_W-1:0]        m_tuser_reg;

    // Breakpoint store: position in the low half, value in the high half.
    assign wr_index    = s_tdata[IDX_LSB +: INDEX_W];
    assign wr_in_range = ({24'd0, wr_index} < 32'(TABLE_POINTS));

    tli_ram #(
        .WIDTH (2*VALUE_W),
        .DEPTH (TABLE_POINTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.ram_write && wr_in_range),
        .waddr (AW'(wr_index)),
        .wdata ({s_tdata[PVAL_LSB +: VALUE_W], s_tdata[PPOS_LSB +: VALUE_W]}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_pos = signed'(rd_data[VALUE_W-1:0]);
    assign rd_val = signed'(rd_data[2*VALUE_W-1:VALUE_W]);

    assign dx  = DIFF_W'(cur_pos_reg) - DIFF_W'(prev_pos_reg);
    assign num = DIFF_W'(q_reg) - DIFF_W'(prev_pos_reg);

    // The first step compares the numerator itself (integer bit), later ones shift.
    assign trial    = cmd.div_first ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign trial_ge = (trial >= {1'b0, dx_reg});

    assign prod_full = signed'({1'b0, quot_reg}) * dy_reg;

    // Arithmetic shift gives the floor of the scaled product.
    assign prod_shr = prod_reg[PROD_W-1:FRAC_W];
    assign sum      = SUM_W'(prev_val_reg) + SUM_W'(prod_shr);

    always_comb begin
        if (sum > SUM_W'(signed'({1'b0, {(VALUE_W-1){1'b1}}}))) begin
            interp_sat = signed'({1'b0, {(VALUE_W-1){1'b1}}});
        end else if (sum < SUM_W'(signed'({1'b1, {(VALUE_W-1){1'b0}}}))) begin
            interp_sat = signed'({1'b1, {(VALUE_W-1){1'b0}}});
        end else begin
            interp_sat = sum[VALUE_W-1:0];
        end
    end

    always_comb begin
        unique case (cmd.src)
            SRC_ZERO:   res_value_next = '0;
            SRC_PREV:   res_value_next = prev_val_reg;
            SRC_READ:   res_value_next = rd_val;
            SRC_INTERP: res_value_next = interp_sat;
            default:    res_value_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_query) begin
            q_reg <= signed'(s_tdata[QPOS_LSB +: VALUE_W]);
        end
        if (cmd.load_prev) begin
            prev_pos_reg <= rd_pos;
            prev_val_reg <= rd_val;
        end
        if (cmd.load_cur) begin
            cur_pos_reg <= rd_pos;
            cur_val_reg <= rd_val;
        end
        if (cmd.load_diff) begin
            dx_reg  <= REM_W'(unsigned'(dx));
            rem_reg <= REM_W'(unsigned'(num));
            dy_reg  <= DIFF_W'(cur_val_reg) - DIFF_W'(prev_val_reg);
        end
        if (cmd.div_step) begin
            rem_reg  <= trial_ge ? REM_W'(trial - {1'b0, dx_reg}) : REM_W'(trial);
            quot_reg <= {quot_reg[QUOT_W-2:0], trial_ge};
        end
        if (cmd.mul) begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
        if (cmd.set_result) begin
            res_value_reg  <= res_value_next;
            res_region_reg <= cmd.region;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= res_value_reg;
            m_tuser_reg <= res_region_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.q_le_read = (q_reg <= rd_pos);
    assign status.q_ge_read = (q_reg >= rd_pos);
    assign status.read_lt_q = (rd_pos < q_reg);
    assign status.dx_pos    = (dx > DIFF_W'(0));
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Every divider step leaves a partial remainder below the divisor.
    `TLI_ASSERT_NXT(a_rem_below_dx, aclk, aresetn, cmd.div_step, rem_reg < dx_reg)
    // A finished result never overwrites one that is still waiting.
    `TLI_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_tvalid_reg || m_tready)

endmodule

// ----- design/tli_ctrl.sv -----
// ----------------------------------------------------------------------------
// Table linear interpolator controller
// Holds points_in_use and sequences each query: end checks, linear search,
// division, multiplication, saturating addition and hand-over to the output register.
// ----------------------------------------------------------------------------
module tli_ctrl #(
    parameter int TABLE_POINTS = tli_pkg::TABLE_POINTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_kind,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tli_pkg::COUNT_W-1:0]     cfg_data,
    input  tli_pkg::dp_status_t             status,
    output tli_pkg::dp_cmd_t                cmd,
    output logic [$clog2(TABLE_POINTS)-1:0] rd_addr
);

    import tli_pkg::*;

    `include "table_linear_interpolator_assert.svh"

    localparam int AW = $clog2(TABLE_POINTS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK0,
        ST_CHKN,
        ST_SRCH,
        ST_DIFF,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   points_reg;
    logic [COUNT_W-1:0]   n_count;
    logic [COUNT_W-1:0]   j_reg, j_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 s_accept;

    // A count beyond the table size is clamped to the table size.
    assign n_count = (32'(points_reg) > 32'(TABLE_POINTS)) ? COUNT_W'(TABLE_POINTS)
                                                             : points_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        rd_addr    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_kind == KIND_WRITE) begin
                    cmd.ram_write = 1'b1;
                end else if (s_accept) begin
                    cmd.load_query = 1'b1;
                    if (n_count == '0) begin
                        cmd.set_result = 1'b1;
                        cmd.src        = SRC_ZERO;
                        cmd.region     = REGION_EMPTY;
                        state_next     = ST_FINISH;
                    end else begin
                        state_next = ST_CHK0;
                    end
                end
            end
            ST_CHK0: begin
                cmd.load_prev = 1'b1;
                if (status.q_le_read) begin
                    cmd.set_result = 1'b1;
                    cmd.src        = SRC_READ;
                    cmd.region     = REGION_LOW;
                    state_next     = ST_FINISH;
                end else begin
                    rd_addr    = AW'(n_count - COUNT_W'(1));
                    state_next = ST_CHKN;
                end
            end
            ST_CHKN: begin
                if (status.q_ge_read) begin
                    cmd.set_result = 1'b1;
                    cmd.src        = SRC_READ;
                    cmd.region     = REGION_HIGH;
                    state_next     = ST_FINISH;
                end else begin
                    j_next     = COUNT_W'(1);
                    rd_addr    = AW'(1);
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                // The last entry lies above the query, so the walk stops by then.
                if (status.read_lt_q) begin
                    cmd.load_prev = 1'b1;
                    j_next        = j_reg + COUNT_W'(1);
                    rd_addr       = AW'(j_reg + COUNT_W'(1));
                end else begin
                    cmd.load_cur = 1'b1;
                    state_next   = ST_DIFF;
                end
            end
            ST_DIFF: begin
                if (!status.dx_pos) begin
                    cmd.set_result = 1'b1;
                    cmd.src        = SRC_PREV;
                    cmd.region     = REGION_FLAT;
                    state_next     = ST_FINISH;
                end else begin
                    cmd.load_diff = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                cnt_next      = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.set_result = 1'b1;
                cmd.src        = SRC_INTERP;
                cmd.region     = REGION_INTERIOR;
                state_next     = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            points_reg <= '0;
            j_reg      <= '0;
            cnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                points_reg <= cfg_data;
            end
        end
    end

    // A query on an empty table goes straight to the output hand-over.
    `TLI_ASSERT_NXT(a_empty_finish, aclk, aresetn, s_accept && s_kind == KIND_QUERY && n_count == '0, state_reg == ST_FINISH)
    // The divider runs exactly the quotient width before multiplying.
    `TLI_ASSERT_NXT(a_div_length, aclk, aresetn, state_reg == ST_DIV && cnt_reg == DIV_CNT_W'(DIV_STEPS - 1), state_reg == ST_MUL)

endmodule

// ----- design/table_linear_interpolator.sv -----
// A query on an empty table goes straight to the output hand-over; a low clamp follows the
// first-entry check, a high clamp the last-entry check, an interval of zero or negative width
// the linear search, and an interior query the search, divider, multiplier and saturating adder.
// A full output register stalls the hand-over. A write is taken while idle; a query holds
// s_tready low until its result is handed over, so the linear search and the divider set the rate.
// Synchronous active-low reset clears points_in_use, control state and m_tvalid, not the RAM.
// ----------------------------------------------------------------------------
// Table linear interpolator
// Piecewise-linear interpolation over a breakpoint table in signed Q16.16.
// ----------------------------------------------------------------------------
module table_linear_interpolator #(
    parameter int TABLE_POINTS = tli_pkg::TABLE_POINTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // point_index[7:0], point_position[39:8], point_value[71:40],
    // query_position[103:72]
    input  logic [tli_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // value[31:0]
    output logic [tli_pkg::VALUE_W-1:0]   m_tdata,
    // region[2:0]
    output logic [tli_pkg::REGION_W-1:0]  m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tli_pkg::COUNT_W-1:0]   cfg_data
);

    import tli_pkg::*;

    localparam int AW = $clog2(TABLE_POINTS);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [AW-1:0] rd_addr;

    tli_ctrl #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_kind    (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    tli_datapath #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .s_tdata  (s_tdata),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- tb/tb_table_linear_interpolator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the table linear interpolator
// Breakpoint writes and queries are streamed in with random gaps while the
// result side stalls at random. Every query result is checked against a
// behavioural interpolation over a shadow copy of the breakpoint table.
// ----------------------------------------------------------------------------
module tb_table_linear_interpolator;
    import tli_pkg::*;

    localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam int ITEM_TARGET   = 1300;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam int CYCLE_LIMIT   = 3_000_000;

    typedef struct {
        logic                      kind;
        logic [INDEX_W-1:0]        slot;
        logic signed [VALUE_W-1:0] pos;
        logic signed [VALUE_W-1:0] val;
        logic signed [VALUE_W-1:0] query;
    } table_item_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        region_t                   region;
    } interp_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = KIND_WRITE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [VALUE_W-1:0]   m_tdata;
    logic [REGION_W-1:0]  m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data  = '0;

    table_item_t    items_to_send[$];
    interp_result_t interp_results_due[$];

    // Shadow of the block's table and point count, updated on accepted beats.
    logic signed [VALUE_W-1:0] shadow_pos [TABLE_POINTS_DEF];
    logic signed [VALUE_W-1:0] shadow_val [TABLE_POINTS_DEF];
    logic [COUNT_W-1:0]        shadow_count = '0;

    // What the stimulus side has loaded, used to aim queries at the intervals.
    logic signed [VALUE_W-1:0] plan_pos [TABLE_POINTS_DEF];
    int plan_n = 0;

    int  items_queued   = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  src_idle_pct   = 19;
    int  sink_idle_pct  = 19;
    int  hold_requests  = 0;
    int  hold_seen      = 0;
    int  hold_left      = 0;
    logic in_beat_taken = 1'b0;

    table_linear_interpolator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic interp_result_t interpolate_at(input logic signed [VALUE_W-1:0] q);
        interp_result_t res;
        int n, i;
        longint dx, num, dy, t, acc;
        n = (shadow_count > TABLE_POINTS_DEF) ? TABLE_POINTS_DEF : int'(shadow_count);
        if (n == 0) begin
            res.value  = '0;
            res.region = REGION_EMPTY;
        end else if (q <= shadow_pos[0]) begin
            res.value  = shadow_val[0];
            res.region = REGION_LOW;
        end else if (q >= shadow_pos[n-1]) begin
            res.value  = shadow_val[n-1];
            res.region = REGION_HIGH;
        end else begin
            i = 0;
            while (i + 1 < n && shadow_pos[i+1] < q)
                i++;
            dx = longint'(shadow_pos[i+1]) - longint'(shadow_pos[i]);
            if (dx <= 0) begin
                res.value  = shadow_val[i];
                res.region = REGION_FLAT;
            end else begin
                num = longint'(q) - longint'(shadow_pos[i]);
                t   = (num <<< FRAC_W) / dx;
                dy  = longint'(shadow_val[i+1]) - longint'(shadow_val[i]);
                // The arithmetic shift rounds the scaled step toward minus infinity.
                acc = longint'(shadow_val[i]) + ((t * dy) >>> FRAC_W);
                if (acc > longint'(Q_MAX))
                    acc = Q_MAX;
                else if (acc < longint'(Q_MIN))
                    acc = Q_MIN;
                res.value  = acc[VALUE_W-1:0];
                res.region = REGION_INTERIOR;
            end
        end
        return res;
    endfunction

    // Source side: a new beat is offered only once the previous one has gone.
    always @(negedge aclk) begin
        table_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_beat_taken) begin
            if (items_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                it = items_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.kind;
                s_tdata  <= {it.query, it.val, it.pos, it.slot};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side, with a long hold-off whenever one is requested.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            m_tready  <= 1'b0;
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        interp_result_t due;
        logic [INDEX_W-1:0] slot;
        cycle_count++;
        in_beat_taken = s_tvalid && s_tready;
        if (aresetn) begin
            // Results are checked before this edge's input beat is predicted.
            if (m_tvalid && m_tready) begin
                if (interp_results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result beat: value %h region %0d",
                                 m_tdata, m_tuser);
                end else begin
                    due = interp_results_due.pop_front();
                    if (m_tdata !== due.value || m_tuser !== due.region) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("result mismatch: expected value %h region %0d, got value %h region %0d",
                                     due.value, due.region, m_tdata, m_tuser);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                shadow_count = cfg_data;
            if (in_beat_taken) begin
                if (s_tuser == KIND_WRITE) begin
                    slot = s_tdata[IDX_LSB +: INDEX_W];
                    shadow_pos[slot] = s_tdata[PPOS_LSB +: VALUE_W];
                    shadow_val[slot] = s_tdata[PVAL_LSB +: VALUE_W];
                end else begin
                    interp_results_due.push_back(interpolate_at(s_tdata[QPOS_LSB +: VALUE_W]));
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("tb_table_linear_interpolator: errors");
        $finish;
    end

    task automatic send_write(input int slot, input logic signed [VALUE_W-1:0] pos,
                              input logic signed [VALUE_W-1:0] val);
        table_item_t it;
        it.kind  = KIND_WRITE;
        it.slot  = INDEX_W'(slot);
        it.pos   = pos;
        it.val   = val;
        it.query = $urandom;
        items_to_send.push_back(it);
        items_queued++;
    endtask

    task automatic send_query(input logic signed [VALUE_W-1:0] q);
        table_item_t it;
        it.kind  = KIND_QUERY;
        it.slot  = $urandom;
        it.pos   = $urandom;
        it.val   = $urandom;
        it.query = q;
        items_to_send.push_back(it);
        items_queued++;
    endtask

    // Returns once nothing is in flight and a trailing write has settled.
    task automatic wait_idle();
        while (items_to_send.size() != 0 || s_tvalid || interp_results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_point_count(input int count);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= COUNT_W'(count);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return int'($urandom_range(262144)) - 131072;
            default: return int'($urandom);
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_query();
        longint lo, hi, q;
        longint unsigned r;
        int k, sel;
        sel = $urandom_range(99);
        r   = {$urandom, $urandom};
        if (plan_n < 2 || sel < 15) begin
            q = int'($urandom);
        end else if (sel < 25) begin
            case ($urandom_range(2))
                0: q = Q_MIN;
                1: q = Q_MAX;
                default: q = 0;
            endcase
        end else begin
            k  = $urandom_range(plan_n - 2);
            lo = plan_pos[k];
            hi = plan_pos[k+1];
            if (sel < 40)
                q = lo;
            else if (sel < 50)
                q = $urandom_range(1) ? lo + 1 : lo - 1;
            else if (sel < 55)
                q = longint'(plan_pos[0]) - longint'(r % 1000);
            else if (sel < 60)
                q = longint'(plan_pos[plan_n-1]) + longint'(r % 1000);
            else if (hi > lo)
                q = lo + longint'(r % longint'(hi - lo + 1));
            else
                q = lo;
        end
        if (q > longint'(Q_MAX))
            q = Q_MAX;
        else if (q < longint'(Q_MIN))
            q = Q_MIN;
        return q[VALUE_W-1:0];
    endfunction

    // Writes slots 0 to n-1, mostly ascending; some tables repeat or shuffle positions.
    task automatic load_table(input int n);
        int raw[$];
        longint p;
        int j, style, step_max;
        plan_n = n;
        style  = $urandom_range(9);
        if (style < 3) begin
            for (j = 0; j < n; j++)
                raw.push_back(int'($urandom));
            if (style != 0)
                raw.sort();
            for (j = 0; j < n; j++)
                plan_pos[j] = raw[j];
        end else begin
            case ($urandom_range(3))
                0: step_max = 4;
                1: step_max = 32'h0001_0000;
                2: step_max = 32'h0100_0000;
                default: step_max = 32'h7FFF_FFFF;
            endcase
            p = longint'(int'($urandom)) >>> $urandom_range(31);
            for (j = 0; j < n; j++) begin
                if (j != 0 && $urandom_range(19) != 0)
                    p += $urandom_range(step_max);
                if (p > longint'(Q_MAX))
                    p = Q_MAX;
                plan_pos[j] = p[VALUE_W-1:0];
            end
        end
        for (j = 0; j < n; j++)
            send_write(j, plan_pos[j], pick_value());
    endtask

    // Queries with the odd breakpoint write mixed in.
    task automatic run_queries(input int count);
        int j, slot;
        for (j = 0; j < count; j++) begin
            if ($urandom_range(99) < 6) begin
                if (plan_n != 0 && $urandom_range(1) != 0)
                    slot = $urandom_range(plan_n - 1);
                else
                    slot = $urandom_range(TABLE_POINTS_DEF - 1);
                if (slot < plan_n)
                    plan_pos[slot] = int'($urandom);
                send_write(slot, (slot < plan_n) ? plan_pos[slot] : int'($urandom),
                           pick_value());
            end
            send_query(pick_query());
        end
    endtask

    initial begin
        int phase, n;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The point count comes out of reset as zero.
        send_query(int'($urandom));

        send_write(0, Q_MIN, Q_MAX);
        send_write(1, -65536, Q_MIN);
        send_write(2, -65536, 12345);
        send_write(3, 32'sh0003_0000, Q_MAX);
        send_write(4, Q_MAX, Q_MIN);
        set_point_count(5);
        send_query(Q_MIN);
        send_query(Q_MAX);
        send_query(Q_MIN + 1);
        send_query(-65536);
        send_query(-65535);
        send_query(32'sh0002_FFFF);
        send_query(Q_MAX - 1);

        set_point_count(1);
        send_query(Q_MIN);
        send_query(0);

        // A descending last breakpoint pulls the upper clamp down.
        send_write(5, 32'sh0001_0000, 7);
        set_point_count(6);
        send_query(32'sh0002_0000);
        send_query(-100);
        send_query(32'sh0000_8000);

        set_point_count(0);
        send_query(Q_MAX);

        // Hold the result side off while the source keeps offering queries.
        set_point_count(8);
        load_table(8);
        hold_requests++;
        run_queries(40);

        phase = 0;
        while (items_queued < ITEM_TARGET) begin
            src_idle_pct  = 19;
            sink_idle_pct = 19;
            if (phase == 3) begin
                n = TABLE_POINTS_DEF;
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else if (phase == 7) begin
                n = $urandom_range(TABLE_POINTS_DEF - 1, 128);
            end else begin
                case ($urandom_range(19))
                    0: n = 0;
                    1: n = 1;
                    2: n = $urandom_range(64, 13);
                    default: n = $urandom_range(12, 2);
                endcase
            end
            set_point_count(n);
            if (n == 0)
                plan_n = 0;
            else
                load_table(n);
            run_queries((n > 64) ? 30 : $urandom_range(24, 4));
            phase++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && interp_results_due.size() == 0)
            $display("tb_table_linear_interpolator: clean");
        else
            $display("tb_table_linear_interpolator: errors");
        $finish;
    end

endmodule
